@@ rtl/joint_count_table_defines.svh @@
// Assertion macros for the checker file of joint_count_table.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef JOINT_COUNT_TABLE_DEFINES_SVH
`define JOINT_COUNT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jct_pkg.sv @@
// Package for joint_count_table: sizes, codes, job and config types,
// and the mixed-radix cell index function. No dependencies.
package jct_pkg;

    localparam int MAX_VARS        = 8;
    localparam int MAX_LABELS      = 4;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int LAB_W   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int ADDR_W  = MAX_VARS + LAB_W;
    localparam int DEPTH   = (1 << MAX_VARS) * MAX_LABELS;
    localparam int NV_W    = 4;   // num_vars / label_slot register width
    localparam int NL_W    = 3;   // num_labels register width
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 4;   // widest register
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_NUM_VARS   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LABEL_USED = 2'd1;
    localparam logic [IDX_W-1:0] REG_LABEL_SLOT = 2'd2;
    localparam logic [IDX_W-1:0] REG_NUM_LABELS = 2'd3;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        JOB_COUNT,
        JOB_QUERY,
        JOB_EMPTY
    } job_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_WR,
        ST_Q_WALK,
        ST_Q_TAIL,
        ST_Q_DONE
    } back_state_t;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [NV_W-1:0] nv;
        logic [NV_W-1:0] slot;
        logic [NL_W-1:0] nl;
        logic            label_used;
    } cfg_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [MAX_VARS-1:0] want;
        logic [MAX_VARS-1:0] gm;
        logic [LAB_W-1:0]    lab_start;
        logic                lab_fixed;
    } job_t;

    // Variable 0 is most significant; the label sits at cfg.slot with radix cfg.nl.
    function automatic logic [ADDR_W-1:0] cell_index(
        input logic [MAX_VARS-1:0] bits,
        input logic [LAB_W-1:0]    lab,
        input cfg_t                cfg
    );
        logic [MAX_VARS-1:0] rev;
        logic [MAX_VARS-1:0] lo_mask;
        logic [MAX_VARS-1:0] hi;
        logic [NV_W-1:0]     low_n;
        logic [ADDR_W-1:0]   mid;
        for (int i = 0; i < MAX_VARS; i++) begin
            rev[i] = bits[MAX_VARS-1-i];
        end
        // unused high variables fall off the bottom here
        rev = rev >> (NV_W'(MAX_VARS) - cfg.nv);
        if (!cfg.label_used) begin
            return ADDR_W'(rev);
        end
        low_n   = cfg.nv - cfg.slot;
        lo_mask = ~({MAX_VARS{1'b1}} << low_n);
        hi      = rev >> low_n;
        mid     = ADDR_W'(hi) * ADDR_W'(cfg.nl) + ADDR_W'(lab);
        return (mid << low_n) | ADDR_W'(rev & lo_mask);
    endfunction

endpackage

@@ rtl/jct_fifo.sv @@
// Short job queue between the front and back parts of joint_count_table.
// Depends on jct_pkg for job_t.
module jct_fifo
    import jct_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/jct_front.sv @@
// Front part of joint_count_table: takes input transfers, drops counts with
// an unknown label, and turns the rest into queue jobs. Depends on jct_pkg.
module jct_front
    import jct_pkg::*;
(
    input  cfg_t                cfg,
    input  logic                clearing,
    input  logic                q_full,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [MAX_VARS-1:0] s_value_bits,
    input  logic [LAB_W-1:0]    s_label_value,
    input  logic [MAX_VARS-1:0] s_given_mask,
    input  logic                s_label_given,
    output logic                push,
    output job_t                push_job
);

    logic [MAX_VARS-1:0] vmask;
    logic [MAX_VARS-1:0] gm;
    logic                lab_ok;
    logic                lab_given_eff;
    logic                take;

    assign s_ready       = !clearing && !q_full;
    assign take          = s_valid && s_ready;
    assign vmask         = ~({MAX_VARS{1'b1}} << cfg.nv);
    assign gm            = s_given_mask & vmask;
    assign lab_ok        = !cfg.label_used || (NL_W'(s_label_value) < cfg.nl);
    assign lab_given_eff = cfg.label_used && s_label_given;

    always_comb begin
        push_job.addr      = cell_index(s_value_bits & vmask,
                                        cfg.label_used ? s_label_value : '0, cfg);
        push_job.want      = s_value_bits & gm;
        push_job.gm        = gm;
        push_job.lab_start = lab_given_eff ? s_label_value : '0;
        push_job.lab_fixed = !cfg.label_used || s_label_given;
        push               = take;
        if (s_cmd == CMD_COUNT) begin
            push_job.kind = JOB_COUNT;
            push          = take && lab_ok;   // unknown label: nothing to count
        end else if (lab_given_eff && !lab_ok) begin
            push_job.kind = JOB_EMPTY;
        end else begin
            push_job.kind = JOB_QUERY;
        end
    end

endmodule

@@ rtl/jct_back.sv @@
// Back part of joint_count_table: the count memory, its clearing pass,
// count read-modify-write, query walk and the result register. Depends on jct_pkg.
module jct_back
    import jct_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               clearing,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TOTAL_W-1:0] m_total
);

    localparam int SW = ((COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W) + 1;
    localparam logic [SW-1:0] ONE_SW = {{(SW-1){1'b0}}, 1'b1};
    localparam logic [SW-1:0] CAP = (COUNT_WIDTH < TOTAL_W) ?
                                    (ONE_SW << COUNT_WIDTH) - ONE_SW :
                                    (ONE_SW << TOTAL_W) - ONE_SW;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    back_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    job_t                job_reg, job_next;
    logic [MAX_VARS-1:0] b_reg, b_next;
    logic [LAB_W-1:0]    l_reg, l_next;
    logic                acc_en_reg, acc_en_next;
    logic [TOTAL_W-1:0]  sum_reg, sum_next;
    logic                m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0]  m_total_reg, m_total_next;

    logic [MAX_VARS-1:0] vmask;
    logic [MAX_VARS:0]   b_inc;
    logic [SW-1:0]       sum_wide;
    logic                l_last;

    assign clearing = (state_reg == ST_CLEAR);
    assign m_valid  = m_valid_reg;
    assign m_total  = m_total_reg;

    assign vmask = ~({MAX_VARS{1'b1}} << cfg.nv);
    // masked increment: steps only the free variables, carry out ends the walk
    assign b_inc = {1'b0, b_reg | job_reg.gm | ~vmask} + {{MAX_VARS{1'b0}}, 1'b1};
    assign l_last = job_reg.lab_fixed || (NL_W'(l_reg) == cfg.nl - 1'b1);
    assign sum_wide = SW'(sum_reg) + SW'(rd_data_reg);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        job_next      = job_reg;
        b_next        = b_reg;
        l_next        = l_reg;
        acc_en_next   = 1'b0;
        sum_next      = sum_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_total_next  = m_total_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = job_reg.addr;
        mem_wdata     = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_WIDTH'(1);
        mem_raddr     = cell_index(b_reg, l_reg, cfg);

        if (acc_en_reg) begin
            sum_next = (sum_wide > CAP) ? TOTAL_W'(CAP) : TOTAL_W'(sum_wide);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    sum_next = '0;
                    unique case (q_head.kind)
                        JOB_COUNT: begin
                            mem_raddr  = q_head.addr;
                            state_next = ST_CNT_WR;
                        end
                        JOB_QUERY: begin
                            b_next     = q_head.want;
                            l_next     = q_head.lab_start;
                            state_next = ST_Q_WALK;
                        end
                        default: begin
                            state_next = ST_Q_DONE;
                        end
                    endcase
                end
            end
            ST_CNT_WR: begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_Q_WALK: begin
                acc_en_next = 1'b1;
                if (!l_last) begin
                    l_next = l_reg + 1'b1;
                end else begin
                    l_next = job_reg.lab_start;
                    b_next = (b_inc[MAX_VARS-1:0] & ~job_reg.gm & vmask) | job_reg.want;
                    if (b_inc[MAX_VARS]) begin
                        state_next = ST_Q_TAIL;
                    end
                end
            end
            ST_Q_TAIL: begin
                // last read lands in the accumulator this cycle
                state_next = ST_Q_DONE;
            end
            ST_Q_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_total_next = sum_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            acc_en_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            acc_en_reg   <= acc_en_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        b_reg       <= b_next;
        l_reg       <= l_next;
        sum_reg     <= sum_next;
        m_total_reg <= m_total_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

@@ rtl/joint_count_table.sv @@
// joint_count_table: joint count table with marginal-sum queries.
// Reset: config returns to defaults, then a clearing pass zeroes all 1024 cells,
//   one per cycle; no input transfer is taken during the clearing pass.
// Count item: memory read, then write in the back end; no result.
// Query item: a walk over 2^F * L cells (F free variables, L labels summed,
//   L = 1 if the label is given or unused); one memory read per walk cycle.
module joint_count_table
    import jct_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [MAX_VARS-1:0] s_value_bits,
    input  logic [LAB_W-1:0]    s_label_value,
    input  logic [MAX_VARS-1:0] s_given_mask,
    input  logic                s_label_given,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TOTAL_W-1:0]  m_total
);

    logic [NV_W-1:0] num_vars_reg;
    logic            label_used_reg;
    logic [NV_W-1:0] label_slot_reg;
    logic [NL_W-1:0] num_labels_reg;

    cfg_t cfg;
    logic clearing;
    logic q_full, q_empty, q_push, q_pop;
    job_t push_job, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vars_reg   <= '0;
            label_used_reg <= 1'b0;
            label_slot_reg <= '0;
            num_labels_reg <= NL_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUM_VARS:   num_vars_reg   <= cfg_wdata[NV_W-1:0];
                REG_LABEL_USED: label_used_reg <= cfg_wdata[0];
                REG_LABEL_SLOT: label_slot_reg <= cfg_wdata[NV_W-1:0];
                REG_NUM_LABELS: num_labels_reg <= cfg_wdata[NL_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp out-of-range settings
    always_comb begin
        cfg.label_used = label_used_reg;
        cfg.nv   = (num_vars_reg > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : num_vars_reg;
        cfg.slot = (label_slot_reg > cfg.nv) ? cfg.nv : label_slot_reg;
        if (num_labels_reg == '0) begin
            cfg.nl = NL_W'(1);
        end else if (num_labels_reg > NL_W'(MAX_LABELS)) begin
            cfg.nl = NL_W'(MAX_LABELS);
        end else begin
            cfg.nl = num_labels_reg;
        end
    end

    jct_front u_front (
        .cfg           (cfg),
        .clearing      (clearing),
        .q_full        (q_full),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_value_bits  (s_value_bits),
        .s_label_value (s_label_value),
        .s_given_mask  (s_given_mask),
        .s_label_given (s_label_given),
        .push          (q_push),
        .push_job      (push_job)
    );

    jct_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    jct_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_total  (m_total)
    );

endmodule

@@ rtl/jct_checker.sv @@
// Port-level checks for joint_count_table, bound to the top level.
// Depends on jct_pkg and joint_count_table_defines.svh.
`include "joint_count_table_defines.svh"

module jct_checker
    import jct_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [TOTAL_W-1:0] m_total
);

    localparam int SW = ((COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W) + 1;
    localparam logic [SW-1:0] ONE_SW = {{(SW-1){1'b0}}, 1'b1};
    localparam logic [SW-1:0] CAP = (COUNT_WIDTH < TOTAL_W) ?
                                    (ONE_SW << COUNT_WIDTH) - ONE_SW :
                                    (ONE_SW << TOTAL_W) - ONE_SW;

    // stalled result transfer holds
    `JCT_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_total), "result dropped or changed while stalled")

    // clearing pass blocks input and shows no result right after reset
    `JCT_ASSERT_NOW(a_clear_start, $rose(aresetn), !s_ready && !m_valid, "block active at start of clearing pass")

    `JCT_ASSERT_NEXT(a_clear_busy, $rose(aresetn), !s_ready && !m_valid, "input taken during clearing pass")

    // a sum never exceeds the saturation cap
    `JCT_ASSERT_NOW(a_total_cap, m_valid, SW'(m_total) <= CAP, "total above saturation cap")

endmodule

bind joint_count_table jct_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_jct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_total (m_total)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for joint_count_table: directed table then random count/query traffic,
// every total checked against a fixed value or an in-bench model of the cell table.
// Depends on jct_pkg and the joint_count_table RTL only.
module tb;
    import jct_pkg::*;

    localparam int          ITEMS_PER_PHASE = 210;
    localparam int          NUM_PHASES      = 8;
    localparam int          DRAIN_CYCLES    = 64;
    localparam int          HOLD_CYCLES     = 600;
    localparam int unsigned CYCLE_LIMIT     = 8_000_000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic                cmd;
        logic [MAX_VARS-1:0] bits;
        logic [LAB_W-1:0]    lab;
        logic [MAX_VARS-1:0] gmask;
        logic                lgiven;
    } doc_item_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]   reg_val;
        doc_item_t          item;
        logic               has_total;
        logic [TOTAL_W-1:0] total;
    } plan_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic                s_cmd;
    logic [MAX_VARS-1:0] s_value_bits;
    logic [LAB_W-1:0]    s_label_value;
    logic [MAX_VARS-1:0] s_given_mask;
    logic                s_label_given;
    logic                m_valid;
    logic                m_ready;
    logic [TOTAL_W-1:0]  m_total;

    joint_count_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_value_bits  (s_value_bits),
        .s_label_value (s_label_value),
        .s_given_mask  (s_given_mask),
        .s_label_given (s_label_given),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_total       (m_total)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------- cell table model ----------------
    logic [TOTAL_W-1:0] cell_count [DEPTH];
    logic [NV_W-1:0]    cfg_nv   = '0;
    logic               cfg_lu   = 1'b0;
    logic [NV_W-1:0]    cfg_slot = '0;
    logic [NL_W-1:0]    cfg_nl   = NL_W'(1);

    logic [TOTAL_W-1:0] expected_totals [$];

    function automatic int unsigned used_vars();
        return (cfg_nv > MAX_VARS) ? MAX_VARS : cfg_nv;
    endfunction

    function automatic int unsigned used_labels();
        if (cfg_nl == 0) return 1;
        return (cfg_nl > MAX_LABELS) ? MAX_LABELS : cfg_nl;
    endfunction

    // Mixed radix, first position most significant; binary variables skip the label slot.
    function automatic int unsigned table_cell(int unsigned bits, int unsigned lab);
        int unsigned nv, nl, slot, npos, idx, v;
        nv   = used_vars();
        nl   = used_labels();
        slot = (cfg_slot > nv) ? nv : cfg_slot;
        npos = nv + (cfg_lu ? 1 : 0);
        idx  = 0;
        for (int unsigned p = 0; p < npos; p++) begin
            if (cfg_lu && p == slot) begin
                idx = idx * nl + lab;
            end else begin
                v   = (cfg_lu && p > slot) ? p - 1 : p;
                idx = idx * 2 + ((bits >> v) & 1);
            end
        end
        return idx % DEPTH;
    endfunction

    // Updates the table for a count; returns 1 with the marginal total for a query.
    function automatic bit apply_to_table(input doc_item_t it,
                                          output logic [TOTAL_W-1:0] total);
        int unsigned nv, nl, vmask, gm, want, nlab, idx;
        longint unsigned sum;
        nv    = used_vars();
        nl    = used_labels();
        vmask = (1 << nv) - 1;
        total = '0;
        if (it.cmd == CMD_COUNT) begin
            if (cfg_lu && it.lab >= nl) return 1'b0;
            idx = table_cell(it.bits & vmask, cfg_lu ? it.lab : 0);
            if (cell_count[idx] != TOTAL_MAX) cell_count[idx] = cell_count[idx] + 1;
            return 1'b0;
        end
        sum  = 0;
        nlab = cfg_lu ? nl : 1;
        gm   = it.gmask & vmask;
        want = it.bits & gm;
        for (int unsigned b = 0; b < (1 << nv); b++) begin
            if ((b & gm) != want) continue;
            for (int unsigned l = 0; l < nlab; l++) begin
                if (cfg_lu && it.lgiven && l != it.lab) continue;
                sum += cell_count[table_cell(b, l)];
                if (sum > TOTAL_MAX) sum = TOTAL_MAX;
            end
        end
        total = sum[TOTAL_W-1:0];
        return 1'b1;
    endfunction

    // ---------------- result checking ----------------
    int                 fail_count = 0;
    logic [TOTAL_W-1:0] want_total;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_totals.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result transfer with no pending query: total %0d", m_total);
            end else begin
                want_total = expected_totals.pop_front();
                if (m_total !== want_total) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("total mismatch: expected %0d, got %0d",
                                 want_total, m_total);
                end
            end
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- result side back-pressure ----------------
    int rx_stall_pct = 0;
    int tx_idle_pct  = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_item(input doc_item_t it, input bit has_total,
                             input logic [TOTAL_W-1:0] total);
        int                 gap;
        logic [TOTAL_W-1:0] sum;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= it.cmd;
        s_value_bits  <= it.bits;
        s_label_value <= it.lab;
        s_given_mask  <= it.gmask;
        s_label_given <= it.lgiven;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (apply_to_table(it, sum))
            expected_totals = {expected_totals, (has_total ? total : sum)};
    endtask

    // Counts give no result, so allow extra cycles for any still in flight.
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_NUM_VARS:   cfg_nv   = val;
            REG_LABEL_USED: cfg_lu   = val[0];
            REG_LABEL_SLOT: cfg_slot = val;
            REG_NUM_LABELS: cfg_nl   = val[NL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic plan_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        plan_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic cmd, input logic [7:0] bits,
                                           input logic [1:0] lab, input logic [7:0] gmask,
                                           input logic lgiven, input logic has_total,
                                           input logic [TOTAL_W-1:0] total);
        plan_row_t r;
        r             = '0;
        r.kind        = ROW_ITEM;
        r.item.cmd    = cmd;
        r.item.bits   = bits;
        r.item.lab    = lab;
        r.item.gmask  = gmask;
        r.item.lgiven = lgiven;
        r.has_total   = has_total;
        r.total       = total;
        return r;
    endfunction

    plan_row_t plan [$];

    function automatic void add_row(input plan_row_t r);
        plan = {plan, r};
    endfunction

    int unsigned phase_nv   [NUM_PHASES] = '{3, 8, 2, 15, 5, 0, 6, 4};
    int unsigned phase_lu   [NUM_PHASES] = '{1, 1, 0, 1, 1, 1, 1, 1};
    int unsigned phase_slot [NUM_PHASES] = '{1, 8, 0, 0, 15, 0, 3, 2};
    int unsigned phase_nl   [NUM_PHASES] = '{3, 4, 1, 7, 2, 4, 0, 4};

    initial begin
        doc_item_t it;
        int        r;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_cmd         = CMD_COUNT;
        s_value_bits  = '0;
        s_label_value = '0;
        s_given_mask  = '0;
        s_label_given = 1'b0;
        m_ready       = 1'b0;
        for (int i = 0; i < DEPTH; i++) cell_count[i] = '0;

        // reset layout: no variables, label off -> everything lands in cell 0
        add_row(item_row(CMD_QUERY, 8'h00, 2'd0, 8'h00, 1'b0, 1'b1, 32'd0));
        add_row(item_row(CMD_COUNT, 8'hFF, 2'd3, 8'hFF, 1'b1, 1'b0, 32'd0));
        add_row(item_row(CMD_COUNT, 8'h00, 2'd0, 8'h00, 1'b0, 1'b0, 32'd0));
        add_row(item_row(CMD_QUERY, 8'hFF, 2'd3, 8'hFF, 1'b1, 1'b1, 32'd2));
        // too many variables, slot past the end, zero labels
        add_row(cfg_row(REG_NUM_VARS, 4'd15));
        add_row(cfg_row(REG_LABEL_USED, 4'd1));
        add_row(cfg_row(REG_LABEL_SLOT, 4'd15));
        add_row(cfg_row(REG_NUM_LABELS, 4'd0));
        add_row(item_row(CMD_COUNT, 8'hFF, 2'd0, 8'h00, 1'b0, 1'b0, 32'd0));
        add_row(item_row(CMD_COUNT, 8'hFF, 2'd1, 8'h00, 1'b0, 1'b0, 32'd0));
        add_row(item_row(CMD_QUERY, 8'hFF, 2'd0, 8'hFF, 1'b1, 1'b0, 32'd0));
        add_row(item_row(CMD_QUERY, 8'h00, 2'd1, 8'h00, 1'b1, 1'b1, 32'd0));
        // label count above the maximum, label first
        add_row(cfg_row(REG_NUM_LABELS, 4'd7));
        add_row(cfg_row(REG_LABEL_SLOT, 4'd0));
        add_row(item_row(CMD_COUNT, 8'h00, 2'd3, 8'h00, 1'b0, 1'b0, 32'd0));
        add_row(item_row(CMD_COUNT, 8'h55, 2'd2, 8'hAA, 1'b1, 1'b0, 32'd0));
        add_row(item_row(CMD_QUERY, 8'h00, 2'd0, 8'h00, 1'b0, 1'b0, 32'd0));
        add_row(item_row(CMD_QUERY, 8'h00, 2'd3, 8'hFF, 1'b1, 1'b0, 32'd0));
        // unused high bits of value and mask
        add_row(cfg_row(REG_NUM_VARS, 4'd4));
        add_row(cfg_row(REG_NUM_LABELS, 4'd4));
        add_row(cfg_row(REG_LABEL_SLOT, 4'd4));
        add_row(item_row(CMD_COUNT, 8'hF0, 2'd1, 8'h00, 1'b0, 1'b0, 32'd0));
        add_row(item_row(CMD_QUERY, 8'hF0, 2'd1, 8'hF0, 1'b0, 1'b0, 32'd0));
        add_row(cfg_row(REG_LABEL_USED, 4'd0));
        add_row(item_row(CMD_COUNT, 8'hAA, 2'd0, 8'h00, 1'b0, 1'b0, 32'd0));
        add_row(item_row(CMD_QUERY, 8'hAA, 2'd2, 8'hFF, 1'b0, 1'b0, 32'd0));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, plan[i].has_total, plan[i].total);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drain();
            write_reg(REG_NUM_VARS,   CFG_W'(phase_nv[p]));
            write_reg(REG_LABEL_USED, CFG_W'(phase_lu[p]));
            write_reg(REG_LABEL_SLOT, CFG_W'(phase_slot[p]));
            write_reg(REG_NUM_LABELS, CFG_W'(phase_nl[p]));
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
                default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 4) hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 1 && n == ITEMS_PER_PHASE / 2) wait_drain();
                it.bits   = MAX_VARS'($urandom);
                it.lgiven = 1'($urandom_range(1));
                if (cfg_lu && $urandom_range(9) != 0)
                    it.lab = LAB_W'($urandom_range(used_labels() - 1));
                else
                    it.lab = LAB_W'($urandom_range(3));
                if ($urandom_range(99) < 35) begin
                    it.cmd = CMD_QUERY;
                    // mostly narrow marginals; a few full-table walks
                    r = $urandom_range(99);
                    if (r < 4) begin
                        it.gmask = '0;
                    end else if (r < 20) begin
                        it.gmask = MAX_VARS'($urandom);
                    end else begin
                        for (int k = 0; k < MAX_VARS; k++)
                            it.gmask[k] = ($urandom_range(99) < 70);
                    end
                end else begin
                    it.cmd   = CMD_COUNT;
                    it.gmask = MAX_VARS'($urandom);
                end
                send_item(it, 1'b0, '0);
            end
        end

        wait_drain();
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
